[hw/rtl/sc3x_pkg.sv]
// Shared types and constants for the 3x3 cross sharpening filter.
// Used by every module of the block but sc3x_ram; depends on nothing else.
`default_nettype none

package sc3x_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_CHANNELS_DEF = 4;

    localparam int ROW_SLOTS   = 3;
    localparam int PIX_W       = 8;
    localparam int ROW_W       = 12;
    localparam int OCOL_W      = 10;
    localparam int OCH_W       = 2;
    localparam int IMG_W_W     = 11;
    localparam int IMG_H_W     = 12;
    localparam int CH_CNT_W    = 3;

    localparam int WIDTH_RST   = 640;
    localparam int HEIGHT_RST  = 480;
    localparam int CHAN_RST    = 1;
    localparam int MIN_WIDTH   = 3;
    localparam int MIN_HEIGHT  = 3;

    localparam int CENTER_GAIN = 5;
    localparam int OFIFO_DEPTH = 8;

    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } t_reg_idx;

    // One result word, packed as it leaves on the output stream.
    typedef struct packed {
        logic                last;
        logic [PIX_W-1:0]    value;
        logic [OCH_W-1:0]    chan;
        logic [OCOL_W-1:0]   col;
        logic [ROW_W-1:0]    row;
    } t_result;

    // Per-word control bits handed from the sequencer to the kernel stage.
    typedef struct packed {
        logic valid;
        logic first_col;
        logic border;
        logic has_res;
        logic last_row;
    } t_item_flags;

endpackage

`default_nettype wire

[hw/rtl/sharpen_3x3_cross_filter.sv]
// Top level of the 3x3 cross sharpening filter: register port, line store,
// sequencer, kernel stage and output queue. Uses sc3x_pkg and all sc3x_ modules.
//
//  Channel    Direction  Width  Contents
//  s_axis     in         8      sample
//  m_axis     out        32+1   out_row, out_column, out_channel, out_value; tlast
//  APB        in/out     32     image_width, image_height, channel_count
//
// One input word per clock on the first and middle rows while the output queue has room;
// the results of a word enter the output queue in the cycle after it is accepted and can be popped from then on.
// On the last row each word makes two results,
// and the single output word per clock then sets the pace of the input.
// The line store takes one write and two reads per word, which fixes the rate.
// Reset and every register write restart the frame at row 0; the store is not
// cleared, as values of rows not written in the current frame never reach a result.
`default_nettype none

module sharpen_3x3_cross_filter #(
    parameter int MAX_WIDTH    = sc3x_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = sc3x_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [7:0] sample

    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [11:0] out_row, [21:12] out_column, [23:22] out_channel, [31:24] out_value
    output logic [31:0]                        m_axis_tdata,
    output logic                               m_axis_tlast,  // last_of_run

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sc3x_pkg::APB_AW-1:0]   paddr,
    input  wire logic [sc3x_pkg::APB_DW-1:0]   pwdata,
    output logic      [sc3x_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DEPTH  = sc3x_pkg::ROW_SLOTS * MAX_WIDTH * MAX_CHANNELS;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW     = sc3x_pkg::PIX_W;
    localparam int RW     = sc3x_pkg::ROW_W;
    localparam int IWW    = sc3x_pkg::IMG_W_W;
    localparam int IHW    = sc3x_pkg::IMG_H_W;
    localparam int NCW    = sc3x_pkg::CH_CNT_W;
    localparam int DW     = sc3x_pkg::APB_DW;
    localparam int CNTW   = $clog2(sc3x_pkg::OFIFO_DEPTH + 1);
    localparam int CREDW  = CNTW + 1;
    localparam int ROOM   = sc3x_pkg::OFIFO_DEPTH - 2;

    logic [IWW-1:0] r_image_width;
    logic [IHW-1:0] r_image_height;
    logic [NCW-1:0] r_channel_count;

    logic                  cfg_wr;
    logic                  restart;
    sc3x_pkg::t_reg_idx    reg_idx;
    logic                  in_accept;

    logic [AW-1:0]         waddr, raddr_a, raddr_b;
    logic [PW-1:0]         rd_a, rd_b;
    sc3x_pkg::t_item_flags flags;
    logic [RW-1:0]         st_row;
    logic [CW-1:0]         st_col;
    logic [CHW-1:0]        st_chan;
    logic [PW-1:0]         st_sample;

    logic [1:0]            push_cnt;
    sc3x_pkg::t_result     res0, res1, head;
    logic [CNTW-1:0]       q_count;

    // Register port.
    assign pready  = 1'b1;
    assign reg_idx = sc3x_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        restart = 1'b0;
        case (reg_idx)
            sc3x_pkg::REG_IMAGE_WIDTH: begin
                prdata  = DW'(r_image_width);
                restart = cfg_wr;
            end
            sc3x_pkg::REG_IMAGE_HEIGHT: begin
                prdata  = DW'(r_image_height);
                restart = cfg_wr;
            end
            sc3x_pkg::REG_CHANNEL_COUNT: begin
                prdata  = DW'(r_channel_count);
                restart = cfg_wr;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= IWW'(sc3x_pkg::WIDTH_RST);
            r_image_height  <= IHW'(sc3x_pkg::HEIGHT_RST);
            r_channel_count <= NCW'(sc3x_pkg::CHAN_RST);
        end else if (cfg_wr) begin
            case (reg_idx)
                sc3x_pkg::REG_IMAGE_WIDTH:   r_image_width   <= pwdata[IWW-1:0];
                sc3x_pkg::REG_IMAGE_HEIGHT:  r_image_height  <= pwdata[IHW-1:0];
                sc3x_pkg::REG_CHANNEL_COUNT: r_channel_count <= pwdata[NCW-1:0];
                default: begin
                end
            endcase
        end
    end

    // A new word is taken only when the queue has room for its results after
    // the word in the kernel stage has pushed its own.
    assign s_axis_tready = (CREDW'(q_count) + CREDW'(push_cnt)) <= CREDW'(ROOM);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    sc3x_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_restart       (restart),
        .i_accept        (in_accept),
        .i_sample        (s_axis_tdata),
        .i_image_width   (r_image_width),
        .i_image_height  (r_image_height),
        .i_channel_count (r_channel_count),
        .o_waddr         (waddr),
        .o_raddr_a       (raddr_a),
        .o_raddr_b       (raddr_b),
        .o_flags         (flags),
        .o_row           (st_row),
        .o_col           (st_col),
        .o_chan          (st_chan),
        .o_sample        (st_sample)
    );

    sc3x_ram #(
        .DATA_W (PW),
        .DEPTH  (DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_we      (in_accept),
        .i_waddr   (waddr),
        .i_wdata   (s_axis_tdata),
        .i_re      (in_accept),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    sc3x_calc #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_calc (
        .i_clk      (i_clk),
        .i_flags    (flags),
        .i_row      (st_row),
        .i_col      (st_col),
        .i_chan     (st_chan),
        .i_sample   (st_sample),
        .i_rd_a     (rd_a),
        .i_rd_b     (rd_b),
        .o_push_cnt (push_cnt),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    sc3x_ofifo u_ofifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_pop      (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_head     (head),
        .o_count    (q_count)
    );

    assign m_axis_tdata = {head.value, head.chan, head.col, head.row};
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

[hw/rtl/sc3x_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered reads.
// Standalone; used for the line store of the sharpening filter.
`default_nettype none

module sc3x_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]                      i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic      [DATA_W-1:0]                      o_rdata_a,
    output logic      [DATA_W-1:0]                      o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sc3x_ctrl.sv]
// Raster sequencer: row, column, channel and row-slot counters, line store
// addressing, and the stage register that follows each accepted word. Uses sc3x_pkg.
`default_nettype none

module sc3x_ctrl #(
    parameter int MAX_WIDTH    = sc3x_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = sc3x_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_restart,
    input  wire logic                          i_accept,
    input  wire logic [sc3x_pkg::PIX_W-1:0]    i_sample,
    input  wire logic [sc3x_pkg::IMG_W_W-1:0]  i_image_width,
    input  wire logic [sc3x_pkg::IMG_H_W-1:0]  i_image_height,
    input  wire logic [sc3x_pkg::CH_CNT_W-1:0] i_channel_count,
    output logic [$clog2(sc3x_pkg::ROW_SLOTS*MAX_WIDTH*MAX_CHANNELS)-1:0] o_waddr,
    output logic [$clog2(sc3x_pkg::ROW_SLOTS*MAX_WIDTH*MAX_CHANNELS)-1:0] o_raddr_a,
    output logic [$clog2(sc3x_pkg::ROW_SLOTS*MAX_WIDTH*MAX_CHANNELS)-1:0] o_raddr_b,
    output sc3x_pkg::t_item_flags              o_flags,
    output logic [sc3x_pkg::ROW_W-1:0]         o_row,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_col,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] o_chan,
    output logic [sc3x_pkg::PIX_W-1:0]         o_sample
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int CHW       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int RW        = sc3x_pkg::ROW_W;
    localparam int NCW       = sc3x_pkg::CH_CNT_W;
    localparam int ROW_WORDS = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW        = $clog2(sc3x_pkg::ROW_SLOTS * ROW_WORDS);
    localparam int LAST_SLOT = sc3x_pkg::ROW_SLOTS - 1;

    logic [RW-1:0]  r_row, n_row;
    logic [CW-1:0]  r_col, n_col;
    logic [CHW-1:0] r_chan, n_chan;
    logic [1:0]     r_slot, n_slot;

    logic [WW-1:0]  w_eff;
    logic [RW-1:0]  h_eff;
    logic [NCW-1:0] nc_eff;
    logic [CW-1:0]  col_last;
    logic [RW-1:0]  row_last;
    logic [CHW-1:0] chan_last;
    logic [1:0]     slot_mid, slot_up;
    logic           is_first_col, is_last_col;
    logic [CW-1:0]  col_right;

    function automatic logic [AW-1:0] word_addr(input logic [1:0] slot,
                                                 input logic [CW-1:0] col,
                                                 input logic [CHW-1:0] chan);
        return AW'(32'(slot) * ROW_WORDS + 32'(col) * MAX_CHANNELS + 32'(chan));
    endfunction

    // Registers are clamped into their legal ranges before use.
    always_comb begin
        if (32'(i_image_width) < sc3x_pkg::MIN_WIDTH) begin
            w_eff = WW'(sc3x_pkg::MIN_WIDTH);
        end else if (32'(i_image_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(i_image_width);
        end
        if (32'(i_image_height) < sc3x_pkg::MIN_HEIGHT) begin
            h_eff = RW'(sc3x_pkg::MIN_HEIGHT);
        end else begin
            h_eff = i_image_height;
        end
        if (i_channel_count == '0) begin
            nc_eff = NCW'(1);
        end else if (32'(i_channel_count) > MAX_CHANNELS) begin
            nc_eff = NCW'(MAX_CHANNELS);
        end else begin
            nc_eff = i_channel_count;
        end
    end

    assign col_last  = CW'(w_eff - WW'(1));
    assign row_last  = h_eff - RW'(1);
    assign chan_last = CHW'(nc_eff - NCW'(1));

    assign is_first_col = (r_col == '0);
    assign is_last_col  = (r_col == col_last);
    assign col_right    = is_last_col ? '0 : r_col + CW'(1);

    // Row r sits in slot r mod 3; the row above in the slot before, two above after.
    assign slot_mid = (r_slot == 2'd0) ? 2'(LAST_SLOT) : r_slot - 2'd1;
    assign slot_up  = (r_slot == 2'(LAST_SLOT)) ? 2'd0 : r_slot + 2'd1;

    // At the first column port A fetches the left edge of the middle row,
    // since the upper neighbour is not needed on a border.
    assign o_waddr   = word_addr(r_slot, r_col, r_chan);
    assign o_raddr_a = is_first_col ? word_addr(slot_mid, '0, r_chan)
                                    : word_addr(slot_up, r_col, r_chan);
    assign o_raddr_b = word_addr(slot_mid, col_right, r_chan);

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_chan = r_chan;
        n_slot = r_slot;
        if (i_restart) begin
            n_row  = '0;
            n_col  = '0;
            n_chan = '0;
            n_slot = '0;
        end else if (i_accept) begin
            if (r_chan >= chan_last) begin
                n_chan = '0;
                if (is_last_col) begin
                    n_col = '0;
                    if (r_row >= row_last) begin
                        n_row  = '0;
                        n_slot = '0;
                    end else begin
                        n_row  = r_row + RW'(1);
                        n_slot = slot_up;
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end else begin
                n_chan = r_chan + CHW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_chan  <= '0;
            r_slot  <= '0;
            o_flags <= '0;
        end else begin
            r_row             <= n_row;
            r_col             <= n_col;
            r_chan            <= n_chan;
            r_slot            <= n_slot;
            o_flags.valid     <= i_accept;
            o_flags.first_col <= is_first_col;
            o_flags.border    <= (r_row == RW'(1)) || is_first_col || is_last_col;
            o_flags.has_res   <= (r_row != '0);
            o_flags.last_row  <= (r_row == row_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            o_row    <= r_row;
            o_col    <= r_col;
            o_chan   <= r_chan;
            o_sample <= i_sample;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sc3x_calc.sv]
// Kernel stage: per-channel window of the middle row, the 5-point cross sum
// with saturation, and formation of the result words. Uses sc3x_pkg.
`default_nettype none

module sc3x_calc #(
    parameter int MAX_WIDTH    = sc3x_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = sc3x_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                       i_clk,
    input  wire sc3x_pkg::t_item_flags      i_flags,
    input  wire logic [sc3x_pkg::ROW_W-1:0] i_row,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  wire logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] i_chan,
    input  wire logic [sc3x_pkg::PIX_W-1:0] i_sample,
    input  wire logic [sc3x_pkg::PIX_W-1:0] i_rd_a,
    input  wire logic [sc3x_pkg::PIX_W-1:0] i_rd_b,
    output logic [1:0]                      o_push_cnt,
    output sc3x_pkg::t_result               o_res0,
    output sc3x_pkg::t_result               o_res1
);

    localparam int PW   = sc3x_pkg::PIX_W;
    localparam int RW   = sc3x_pkg::ROW_W;
    localparam int OCW  = sc3x_pkg::OCOL_W;
    localparam int OCHW = sc3x_pkg::OCH_W;
    localparam int POSW = PW + 3;
    localparam int NEGW = PW + 2;
    localparam int MAXV = (1 << PW) - 1;

    // Left and centre samples of the middle row, one pair per channel.
    logic [PW-1:0] r_left [MAX_CHANNELS];
    logic [PW-1:0] r_mid  [MAX_CHANNELS];

    logic [PW-1:0]   left_px, mid_px;
    logic [POSW-1:0] pos_sum;
    logic [NEGW-1:0] neg_sum;
    logic [POSW-1:0] diff;
    logic [PW-1:0]   sat_val;

    assign left_px = r_left[i_chan];
    assign mid_px  = r_mid[i_chan];

    // Port A holds the upper neighbour, port B the right neighbour; the
    // current input word is the lower neighbour.
    assign pos_sum = POSW'(mid_px) * POSW'(sc3x_pkg::CENTER_GAIN);
    assign neg_sum = NEGW'(left_px) + NEGW'(i_rd_b) + NEGW'(i_rd_a) + NEGW'(i_sample);
    assign diff    = pos_sum - POSW'(neg_sum);

    always_comb begin
        if (POSW'(neg_sum) > pos_sum) begin
            sat_val = '0;
        end else if (diff > POSW'(MAXV)) begin
            sat_val = PW'(MAXV);
        end else begin
            sat_val = PW'(diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flags.valid) begin
            if (i_flags.first_col) begin
                r_left[i_chan] <= i_rd_a;
            end else begin
                r_left[i_chan] <= mid_px;
            end
            r_mid[i_chan] <= i_rd_b;
        end
    end

    always_comb begin
        o_res0.row   = i_row - RW'(1);
        o_res0.col   = OCW'(i_col);
        o_res0.chan  = OCHW'(i_chan);
        o_res0.value = i_flags.border ? '0 : sat_val;
        o_res0.last  = !i_flags.last_row;

        o_res1.row   = i_row;
        o_res1.col   = OCW'(i_col);
        o_res1.chan  = OCHW'(i_chan);
        o_res1.value = '0;
        o_res1.last  = 1'b1;

        if (i_flags.valid) begin
            o_push_cnt = 2'(i_flags.has_res) + 2'(i_flags.last_row);
        end else begin
            o_push_cnt = 2'd0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sc3x_ofifo.sv]
// Output queue of result words: up to two pushes and one pop per cycle.
// Uses sc3x_pkg for the result type and the depth.
`default_nettype none

module sc3x_ofifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [1:0]        i_push_cnt,
    input  wire sc3x_pkg::t_result i_res0,
    input  wire sc3x_pkg::t_result i_res1,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output sc3x_pkg::t_result      o_head,
    output logic [$clog2(sc3x_pkg::OFIFO_DEPTH + 1)-1:0] o_count
);

    localparam int DEPTH = sc3x_pkg::OFIFO_DEPTH;
    localparam int PTRW  = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    sc3x_pkg::t_result r_mem [DEPTH];

    logic [PTRW-1:0] r_wr, n_wr;
    logic [PTRW-1:0] r_rd, n_rd;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

    always_comb begin
        n_wr  = r_wr + PTRW'(i_push_cnt);
        n_rd  = r_rd + PTRW'(pop_ok);
        n_cnt = r_cnt + CNTW'(i_push_cnt) - CNTW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr + PTRW'(1)] <= i_res1;
        end
    end

endmodule

`default_nettype wire

[tb/sharpen_result_checker.sv]
// Result checker for the 3x3 cross sharpening filter: mirrors the register port,
// predicts every output word from the accepted samples and compares it in order.
// Depends on sc3x_pkg for the result layout, register indexes and sizes.
module sharpen_result_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [7:0] sample
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [11:0] out_row, [21:12] out_column, [23:22] out_channel, [31:24] out_value
    input  wire logic [31:0]                   m_axis_tdata,
    input  wire logic                          m_axis_tlast,   // last_of_run
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sc3x_pkg::APB_AW-1:0]   paddr,
    input  wire logic [sc3x_pkg::APB_DW-1:0]   pwdata,
    input  wire logic [sc3x_pkg::APB_DW-1:0]   prdata,
    input  wire logic                          pready,
    output int                                 o_fail_count,
    output int                                 o_outstanding
);
    import sc3x_pkg::*;

    localparam int LINE_DEPTH = ROW_SLOTS * MAX_WIDTH_DEF * MAX_CHANNELS_DEF;

    logic [PIX_W-1:0]    line_mem [LINE_DEPTH];
    logic [IMG_W_W-1:0]  cfg_width;
    logic [IMG_H_W-1:0]  cfg_height;
    logic [CH_CNT_W-1:0] cfg_chans;
    int                  cur_row;
    int                  cur_col;
    int                  cur_chan;
    int                  fails = 0;
    t_result             expected_words [$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    function automatic int line_index(int slot, int col, int chan);
        return (slot * MAX_WIDTH_DEF + col) * MAX_CHANNELS_DEF + chan;
    endfunction

    function automatic int eff_width();
        int w;
        w = int'(cfg_width);
        if (w < MIN_WIDTH) w = MIN_WIDTH;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(cfg_height);
        if (h < MIN_HEIGHT) h = MIN_HEIGHT;
        return h;
    endfunction

    function automatic int eff_chans();
        int c;
        c = int'(cfg_chans);
        if (c < 1) c = 1;
        if (c > MAX_CHANNELS_DEF) c = MAX_CHANNELS_DEF;
        return c;
    endfunction

    function automatic int pix(int slot, int col, int chan);
        return int'(line_mem[line_index(slot, col, chan)]);
    endfunction

    task automatic apply_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        case (addr[3:2])
            REG_IMAGE_WIDTH:   cfg_width  = data[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT:  cfg_height = data[IMG_H_W-1:0];
            REG_CHANNEL_COUNT: cfg_chans  = data[CH_CNT_W-1:0];
            default: return;
        endcase
        // Any register write starts a new frame.
        cur_row  = 0;
        cur_col  = 0;
        cur_chan = 0;
    endtask

    task automatic check_read(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        logic [APB_DW-1:0] want;
        case (addr[3:2])
            REG_IMAGE_WIDTH:   want = APB_DW'(cfg_width);
            REG_IMAGE_HEIGHT:  want = APB_DW'(cfg_height);
            REG_CHANNEL_COUNT: want = APB_DW'(cfg_chans);
            default: return;
        endcase
        if (data !== want) begin
            $display("%0t: register %0d read expected %0d, actual %0d",
                     $time, addr[3:2], want, data);
            fails++;
        end
    endtask

    task automatic sharpen_predict(input logic [PIX_W-1:0] sample);
        int      w;
        int      h;
        int      nch;
        int      acc;
        int      mid;
        int      n;
        t_result found [2];
        w   = eff_width();
        h   = eff_height();
        nch = eff_chans();
        n   = 0;
        line_mem[line_index(cur_row % ROW_SLOTS, cur_col, cur_chan)] = sample;
        // A sample of row r completes the window of the same place in row r-1.
        if (cur_row >= 1) begin
            acc = 0;
            if (cur_row - 1 != 0 && cur_col != 0 && cur_col != w - 1) begin
                mid = (cur_row - 1) % ROW_SLOTS;
                acc = CENTER_GAIN * pix(mid, cur_col, cur_chan)
                    - pix(mid, cur_col - 1, cur_chan)
                    - pix(mid, cur_col + 1, cur_chan)
                    - pix((cur_row + 1) % ROW_SLOTS, cur_col, cur_chan)
                    - pix(cur_row % ROW_SLOTS, cur_col, cur_chan);
                if (acc < 0) acc = 0;
                if (acc > 255) acc = 255;
            end
            found[n].last  = 1'b0;
            found[n].value = PIX_W'(acc);
            found[n].chan  = OCH_W'(cur_chan);
            found[n].col   = OCOL_W'(cur_col);
            found[n].row   = ROW_W'(cur_row - 1);
            n++;
        end
        // The bottom row has no window of its own, so it also yields a zero.
        if (cur_row == h - 1) begin
            found[n].last  = 1'b0;
            found[n].value = '0;
            found[n].chan  = OCH_W'(cur_chan);
            found[n].col   = OCOL_W'(cur_col);
            found[n].row   = ROW_W'(cur_row);
            n++;
        end
        if (n > 0) found[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_words.push_back(found[i]);

        cur_chan++;
        if (cur_chan >= nch) begin
            cur_chan = 0;
            cur_col++;
            if (cur_col >= w) begin
                cur_col = 0;
                cur_row++;
                if (cur_row >= h) cur_row = 0;
            end
        end
    endtask

    task automatic compare_field(input string label, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
            fails++;
        end
    endtask

    task automatic check_word(input t_result got);
        t_result want;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word row %0d col %0d chan %0d value %0d last %0b",
                     $time, got.row, got.col, got.chan, got.value, got.last);
            fails++;
            return;
        end
        want = expected_words.pop_front();
        compare_field("out_row", int'(want.row), int'(got.row));
        compare_field("out_column", int'(want.col), int'(got.col));
        compare_field("out_channel", int'(want.chan), int'(got.chan));
        compare_field("out_value", int'(want.value), int'(got.value));
        compare_field("last_of_run", int'(want.last), int'(got.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width  = IMG_W_W'(WIDTH_RST);
            cfg_height = IMG_H_W'(HEIGHT_RST);
            cfg_chans  = CH_CNT_W'(CHAN_RST);
            cur_row    = 0;
            cur_col    = 0;
            cur_chan   = 0;
            expected_words.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) apply_write(paddr, pwdata);
                else check_read(paddr, prdata);
            end
            // Output first: a word leaving now never belongs to a sample taken now.
            if (m_axis_tvalid && m_axis_tready) check_word({m_axis_tlast, m_axis_tdata});
            if (s_axis_tvalid && s_axis_tready) sharpen_predict(s_axis_tdata);
        end
        o_outstanding <= expected_words.size();
        o_fail_count  <= fails;
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the 3x3 cross sharpening filter: clock, reset, register setup,
// sample stimulus, output back-pressure and the verdict. Needs sc3x_pkg, the filter
// RTL and sharpen_result_checker.
module tb_top;
    import sc3x_pkg::*;

    localparam int IDLE_MAX       = 13;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 16;
    localparam int UNUSED_REG_IDX = 3;
    localparam int RANDOM_ITEMS   = 200;

    // Three 3x3 frames: a bright cross, a dark hole and a lone bright dot.
    localparam logic [7:0] DIRECTED_PIX [27] = '{
        8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd0,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0
    };

    typedef enum int {PAT_UNIFORM, PAT_EXTREME, PAT_FLAT, PAT_SPIKE} pattern_t;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;    // [7:0] sample
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // [11:0] out_row, [21:12] out_column, [23:22] out_channel, [31:24] out_value
    logic [31:0]       m_axis_tdata;
    logic              m_axis_tlast;          // last_of_run
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                outstanding;
    bit                idle_on      = 1'b1;
    bit                hold_pending = 1'b0;
    logic [7:0]        flat_level   = 8'd128;

    sharpen_3x3_cross_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sharpen_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Output side: a random stall before each word while idle_on is set, one long hold when asked.
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic apb_access(input logic is_write, input int idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int w, input int h, input int c);
        apb_access(1'b1, REG_IMAGE_WIDTH, w);
        apb_access(1'b1, REG_IMAGE_HEIGHT, h);
        apb_access(1'b1, REG_CHANNEL_COUNT, c);
        apb_access(1'b0, REG_IMAGE_WIDTH, '0);
        apb_access(1'b0, REG_IMAGE_HEIGHT, '0);
        apb_access(1'b0, REG_CHANNEL_COUNT, '0);
    endtask

    function automatic logic [7:0] pick_sample(pattern_t mode);
        case (mode)
            PAT_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            PAT_FLAT:    return flat_level + 8'($urandom_range(0, 6));
            PAT_SPIKE:   return ($urandom_range(0, 7) == 0) ? 8'd255
                                                            : 8'($urandom_range(0, 15));
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Returns at the edge where the word is taken.
    task automatic send_sample(input logic [7:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every predicted word has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_items(input int n, input pattern_t mode);
        flat_level = 8'($urandom_range(0, 249));
        for (int k = 0; k < n; k++) begin
            if (k > 0 && $urandom_range(0, 63) == 0) drain();
            send_sample(pick_sample(mode));
        end
        drain();
    endtask

    initial begin
        int random_items;
        int n;
        int w;
        int h;
        int c;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register values after reset, then a few words at the reset geometry.
        apb_access(1'b0, REG_IMAGE_WIDTH, '0);
        apb_access(1'b0, REG_IMAGE_HEIGHT, '0);
        apb_access(1'b0, REG_CHANNEL_COUNT, '0);
        run_items(20, PAT_UNIFORM);

        configure(3, 3, 1);
        for (int k = 0; k < 27; k++) send_sample(DIRECTED_PIX[k]);
        drain();

        // A write outside the register map must not restart the frame.
        configure(4, 3, 2);
        run_items(10, PAT_UNIFORM);
        apb_access(1'b1, UNUSED_REG_IDX, 32'h5);
        run_items(30, PAT_UNIFORM);

        // The output side holds off once so the queue fills and the input stalls.
        configure(8, 4, 1);
        hold_pending = 1'b1;
        run_items(40, PAT_SPIKE);

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 2);
                default: w = $urandom_range(3, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       h = $urandom_range(0, 2);
                1:       h = 4095;
                default: h = $urandom_range(3, 6);
            endcase
            c = $urandom_range(0, 7);
            idle_on = ($urandom_range(0, 3) != 0);
            configure(w, h, c);
            n = $urandom_range(10, 70);
            run_items(n, pattern_t'($urandom_range(0, 3)));
            random_items += n;
        end

        // All-ones width and channel fields clamp to the largest sizes.
        idle_on = 1'b0;
        configure(2047, 0, 7);
        run_items(30, PAT_EXTREME);

        idle_on = 1'b1;
        configure(1, 4095, 0);
        run_items(30, PAT_UNIFORM);

        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
